// ----- rtl/bch_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bch_pkg;

  // defaults for the top-level parameters
  localparam int MAX_READ_LEN_DEF = 1024;
  localparam int COUNT_BITS_DEF   = 32;

  // fixed field widths
  localparam int POS_W     = 10;
  localparam int BASE_W    = 3;
  localparam int OUT_CNT_W = 32;
  localparam int NUM_HIST  = 6;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 240;

  // base codes
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  // register word indexes
  localparam logic REG_INCLUDE_CPG = 1'b0;

  // histogram selector, also the counter slot within one memory row
  typedef enum logic [2:0] {
    SEL_FWD_UNCONV = 3'd0,
    SEL_FWD_CONV   = 3'd1,
    SEL_FWD_ERR    = 3'd2,
    SEL_REV_UNCONV = 3'd3,
    SEL_REV_CONV   = 3'd4,
    SEL_REV_ERR    = 3'd5
  } hist_sel_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ctrl_state_t;

  // one decoded beat handed to the read-modify-write stage
  typedef struct packed {
    logic             is_read;
    logic             inc;
    hist_sel_t        sel;
    logic             in_range;
    logic [POS_W-1:0] pos;
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/bisulfite_conversion_histogram_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | beat contents
// ----------+-----+---------------------------------------------------------
// s_*       | in  | one aligned base to count, or a request to read one bin
// m_*       | out | the six counts of one bin plus the overhang total
// apb       | in  | register include_cpg at byte address 0
//
// after reset a clearing pass writes every bin to zero, one row a cycle;
// s_tready stays low during it, apb writes are still taken, a setup phase
// then an access phase; a count beat passes through a registered memory
// read and then a write-back, the last write being forwarded to the row read
// a read beat is loaded into the output register after its memory read, once
// that register is empty or being drained, and holds s_tready low only while
// the output register is full and m_tready is low

module bisulfite_conversion_histogram_unit
  import bch_pkg::*;
#(
  parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // stream in
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // on_neg_strand[0], read_pos[10:1], ref_base[13:11], context_base[16:14],
  // at_chrom_edge[17], off_chrom[18], read_base[21:19], zero fill
  input  wire logic [IN_W-1:0]   s_tdata,
  // kind[0]
  input  wire logic              s_tuser,
  // stream out
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // bin_index[9:0], fwd_unconverted[41:10], fwd_converted[73:42],
  // fwd_errors[105:74], rev_unconverted[137:106], rev_converted[169:138],
  // rev_errors[201:170], overhang_total[233:202], zero fill
  output logic [OUT_W-1:0]       m_tdata,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = $clog2(MAX_READ_LEN);

  ctrl_state_t            state;
  ctrl_state_t            state_next;
  logic [AW-1:0]          clr_addr;
  logic                   clr_en;
  logic                   run;
  logic                   include_cpg;
  logic [COUNT_BITS-1:0]  overhang;
  logic                   adv;
  logic                   in_acc;
  op_t                    op;

  // input fields
  logic                   on_neg_strand;
  logic [POS_W-1:0]       read_pos;
  logic [BASE_W-1:0]      ref_base;
  logic [BASE_W-1:0]      context_base;
  logic                   at_chrom_edge;
  logic                   off_chrom;
  logic [BASE_W-1:0]      read_base;
  logic                   in_range;
  logic                   cpg;
  logic [BASE_W-1:0]      target;
  logic [BASE_W-1:0]      partner;

  assign on_neg_strand = s_tdata[0];
  assign read_pos      = s_tdata[10:1];
  assign ref_base      = s_tdata[13:11];
  assign context_base  = s_tdata[16:14];
  assign at_chrom_edge = s_tdata[17];
  assign off_chrom     = s_tdata[18];
  assign read_base     = s_tdata[21:19];

  // apb: always ready, one register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INCLUDE_CPG) ? {31'b0, include_cpg} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      include_cpg <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_INCLUDE_CPG) begin
      include_cpg <= pwdata[0];
    end
  end

  // clearing pass then normal running
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_READ_LEN - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_en = 1'b0;
    run    = 1'b0;
    case (state)
      ST_CLEAR: clr_en = 1'b1;
      ST_RUN:   run    = 1'b1;
      default:  clr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clr_en) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign s_tready = run && adv;
  assign in_acc   = s_tvalid && s_tready;

  // decode: the cytosine lies on the reference C (forward) or G (reverse)
  assign in_range = 32'(read_pos) < 32'(MAX_READ_LEN);
  assign target   = on_neg_strand ? BASE_G : BASE_C;
  assign partner  = on_neg_strand ? BASE_C : BASE_G;
  // the chromosome edge rules out cpg context
  assign cpg      = !at_chrom_edge && context_base == partner;

  always_comb begin
    op          = '0;
    op.is_read  = s_tuser;
    op.pos      = read_pos;
    op.in_range = in_range;
    op.inc      = !s_tuser && !off_chrom && in_range && ref_base == target &&
                  (!cpg || include_cpg) && read_base != BASE_N;
    if (read_base == BASE_C) begin
      op.sel = on_neg_strand ? SEL_REV_UNCONV : SEL_FWD_UNCONV;
    end else if (read_base == BASE_T) begin
      op.sel = on_neg_strand ? SEL_REV_CONV : SEL_FWD_CONV;
    end else begin
      op.sel = on_neg_strand ? SEL_REV_ERR : SEL_FWD_ERR;
    end
  end

  // overhang counts as the beat is taken, ahead of any later read beat
  always_ff @(posedge clk) begin
    if (rst) begin
      overhang <= '0;
    end else if (in_acc && !s_tuser && off_chrom && overhang != {COUNT_BITS{1'b1}}) begin
      overhang <= overhang + 1'b1;
    end
  end

  bch_rmw #(
    .MAX_READ_LEN (MAX_READ_LEN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_rmw (
    .clk      (clk),
    .rst      (rst),
    .in_op    (op),
    .in_acc   (in_acc),
    .ovh      (overhang),
    .clr_en   (clr_en),
    .clr_addr (clr_addr),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/bch_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bch_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 192,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bch_rmw.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bch_rmw
  import bch_pkg::*;
#(
  parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire op_t                         in_op,
  input  wire logic                        in_acc,
  input  wire logic [COUNT_BITS-1:0]       ovh,
  input  wire logic                        clr_en,
  input  wire logic [$clog2(MAX_READ_LEN)-1:0] clr_addr,
  output logic                             adv,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [OUT_W-1:0]                 m_tdata
);

  localparam int AW    = $clog2(MAX_READ_LEN);
  localparam int ROW_W = NUM_HIST * COUNT_BITS;
  localparam logic [63:0] OUT_LIMIT = 64'h0000_0000_FFFF_FFFF;

  function automatic logic [OUT_CNT_W-1:0] clip(input logic [COUNT_BITS-1:0] c);
    logic [63:0] c64;
    c64 = 64'(c);
    return (c64 > OUT_LIMIT) ? {OUT_CNT_W{1'b1}} : c64[OUT_CNT_W-1:0];
  endfunction

  logic             s1_valid;
  op_t              s1_op;
  logic [AW-1:0]    s1_addr;
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [ROW_W-1:0] fwd_data;
  logic             s1_wr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [OUT_W-1:0] out_word;

  assign s1_addr = AW'(s1_op.pos);
  assign s1_wr   = s1_valid && s1_op.inc;

  // the write of the previous item can land on the edge that read this row
  assign row_cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;

  always_comb begin
    logic [COUNT_BITS-1:0] c;
    row_new = row_cur;
    for (int j = 0; j < NUM_HIST; j++) begin
      c = row_cur[j*COUNT_BITS +: COUNT_BITS];
      if (s1_op.sel == hist_sel_t'(3'(j)) && c != {COUNT_BITS{1'b1}}) begin
        row_new[j*COUNT_BITS +: COUNT_BITS] = c + 1'b1;
      end
    end
  end

  assign mem_we    = clr_en || s1_wr;
  assign mem_waddr = clr_en ? clr_addr : s1_addr;
  assign mem_wdata = clr_en ? '0 : row_new;

  bch_mem #(
    .DEPTH (MAX_READ_LEN),
    .WIDTH (ROW_W),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_acc),
    .raddr (AW'(in_op.pos)),
    .rdata (rd_data)
  );

  assign adv = !s1_valid || !s1_op.is_read || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= in_acc;
      end
      if (s1_wr) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op <= in_op;
    end
    if (s1_wr) begin
      fwd_addr <= s1_addr;
      fwd_data <= row_new;
    end
  end

  always_comb begin
    out_word = '0;
    out_word[POS_W-1:0] = s1_op.pos;
    for (int j = 0; j < NUM_HIST; j++) begin
      out_word[POS_W + j*OUT_CNT_W +: OUT_CNT_W] =
        s1_op.in_range ? clip(row_cur[j*COUNT_BITS +: COUNT_BITS]) : '0;
    end
    out_word[POS_W + NUM_HIST*OUT_CNT_W +: OUT_CNT_W] = clip(ovh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_valid && s1_op.is_read && adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_op.is_read && adv) begin
      m_tdata <= out_word;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bch_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bch_checker
  import bch_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [IN_W-1:0]  s_tdata,
  input wire logic             s_tuser,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // clearing pass blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // an unstalled result comes from the read beat taken ahead of it, through the memory read and output registers
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
    else $error("result without read beat");

  a_out_bin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata[9:0] == $past(s_tdata[10:1], 2))
    else $error("reported bin differs from requested bin");

endmodule

bind bisulfite_conversion_histogram_unit bch_checker u_bch_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/bisulfite_conversion_histogram_unit_test.sv -----
`timescale 1ns / 1ps

module bisulfite_conversion_histogram_unit_test;
  import bch_pkg::*;

  localparam int NUM_BINS      = MAX_READ_LEN_DEF;
  // the longest correct quiet spell is the clearing pass after reset
  localparam int STALL_LIMIT   = 5000;
  // read beats pass the read and output registers, count beats a write-back
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS  = 1500;
  localparam int NUM_PHASES    = 4;

  // base codes not named in the package
  localparam logic [BASE_W-1:0] BASE_A        = 3'd0;
  localparam logic [BASE_W-1:0] BASE_OTHER    = 3'd5;
  localparam logic [BASE_W-1:0] BASE_SPARE_LO = 3'd6;
  localparam logic [BASE_W-1:0] BASE_SPARE_HI = 3'd7;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam logic STRAND_FWD = 1'b0;
  localparam logic STRAND_REV = 1'b1;

  // one input beat, laid out as {s_tuser, s_tdata[21:0]}
  typedef struct packed {
    logic              kind;
    logic [BASE_W-1:0] read_base;
    logic              off_chrom;
    logic              at_chrom_edge;
    logic [BASE_W-1:0] context_base;
    logic [BASE_W-1:0] ref_base;
    logic [POS_W-1:0]  read_pos;
    logic              on_neg_strand;
  } base_beat_t;

  // one output beat, laid out as m_tdata[233:0]
  typedef struct packed {
    logic [OUT_CNT_W-1:0] overhang_total;
    logic [OUT_CNT_W-1:0] rev_errors;
    logic [OUT_CNT_W-1:0] rev_converted;
    logic [OUT_CNT_W-1:0] rev_unconverted;
    logic [OUT_CNT_W-1:0] fwd_errors;
    logic [OUT_CNT_W-1:0] fwd_converted;
    logic [OUT_CNT_W-1:0] fwd_unconverted;
    logic [POS_W-1:0]     bin_index;
  } bin_report_t;

  // shadow histograms plus the queue of bin reports still owed by the block
  class conversion_tally;
    logic [OUT_CNT_W-1:0] counts [NUM_HIST][NUM_BINS];
    logic [OUT_CNT_W-1:0] overhang;
    logic                 cpg_on;
    bin_report_t          pending [$];
    int                   mismatches;
    int                   reports_seen;

    function new();
      foreach (counts[h, b]) counts[h][b] = '0;
      overhang     = '0;
      cpg_on       = 1'b0;
      mismatches   = 0;
      reports_seen = 0;
    endfunction

    function logic [OUT_CNT_W-1:0] sat_inc(logic [OUT_CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function logic [OUT_CNT_W-1:0] field_of(bin_report_t r, int i);
      logic [$bits(bin_report_t)-1:0] v;
      v = r;
      if (i == 0) return OUT_CNT_W'(r.bin_index);
      return v[POS_W + OUT_CNT_W * (i - 1) +: OUT_CNT_W];
    endfunction

    // called for every accepted input beat, in order of acceptance
    function void note_base(base_beat_t b);
      logic [BASE_W-1:0] target;
      logic [BASE_W-1:0] partner;
      logic              in_cpg;
      hist_sel_t         sel;
      bin_report_t       r;
      if (b.kind == KIND_READ) begin
        r.bin_index       = b.read_pos;
        r.fwd_unconverted = counts[SEL_FWD_UNCONV][b.read_pos];
        r.fwd_converted   = counts[SEL_FWD_CONV][b.read_pos];
        r.fwd_errors      = counts[SEL_FWD_ERR][b.read_pos];
        r.rev_unconverted = counts[SEL_REV_UNCONV][b.read_pos];
        r.rev_converted   = counts[SEL_REV_CONV][b.read_pos];
        r.rev_errors      = counts[SEL_REV_ERR][b.read_pos];
        r.overhang_total  = overhang;
        pending.insert(pending.size(), r);
        return;
      end
      // past the chromosome end nothing but the overhang moves
      if (b.off_chrom) begin
        overhang = sat_inc(overhang);
        return;
      end
      target  = b.on_neg_strand ? BASE_G : BASE_C;
      partner = b.on_neg_strand ? BASE_C : BASE_G;
      // a neighbour outside the chromosome never makes a cpg
      in_cpg  = !b.at_chrom_edge && (b.context_base == partner);
      if (b.ref_base != target || (in_cpg && !cpg_on)) return;
      if (b.read_base == BASE_N) return;
      if (b.read_base == BASE_C)
        sel = b.on_neg_strand ? SEL_REV_UNCONV : SEL_FWD_UNCONV;
      else if (b.read_base == BASE_T)
        sel = b.on_neg_strand ? SEL_REV_CONV : SEL_FWD_CONV;
      else
        sel = b.on_neg_strand ? SEL_REV_ERR : SEL_FWD_ERR;
      counts[sel][b.read_pos] = sat_inc(counts[sel][b.read_pos]);
    endfunction

    function void check_report(bin_report_t got);
      bin_report_t want;
      string names [8] = '{"bin_index", "fwd_unconverted", "fwd_converted",
                           "fwd_errors", "rev_unconverted", "rev_converted",
                           "rev_errors", "overhang_total"};
      if (pending.size() == 0) begin
        $display("%0t: unexpected bin report, bin %0d", $time, got.bin_index);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      reports_seen++;
      for (int i = 0; i < 8; i++) begin
        if (field_of(want, i) !== field_of(got, i)) begin
          $display("%0t: %s at bin %0d expected %0d actual %0d", $time, names[i],
                   want.bin_index, field_of(want, i), field_of(got, i));
          mismatches++;
        end
      end
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // on_neg_strand[0], read_pos[10:1], ref_base[13:11], context_base[16:14],
  // at_chrom_edge[17], off_chrom[18], read_base[21:19], zero fill
  logic [IN_W-1:0]   s_tdata  = '0;
  // kind[0]
  logic              s_tuser  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  // bin_index[9:0], fwd_unconverted[41:10], fwd_converted[73:42],
  // fwd_errors[105:74], rev_unconverted[137:106], rev_converted[169:138],
  // rev_errors[201:170], overhang_total[233:202], zero fill
  logic [OUT_W-1:0]  m_tdata;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [2:0]        paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  conversion_tally tally;
  // while set, neither side idles: beats run back to back, often on hot bins
  bit              calm          = 1'b0;
  int              idle_cycles   = 0;
  int              counts_sent   = 0;
  int              reads_sent    = 0;
  int              settings_used = 0;

  bisulfite_conversion_histogram_unit dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver holds off about 30 percent of the time outside calm stretches
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 30);
  end

  // sample both sides on the pre-edge values; also the stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) tally.check_report(bin_report_t'(m_tdata[233:0]));
      if (s_tvalid && s_tready) tally.note_base(base_beat_t'({s_tuser, s_tdata[21:0]}));
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic base_beat_t beat(logic kind, logic neg, logic [POS_W-1:0] pos,
                                      logic [BASE_W-1:0] ref_code,
                                      logic [BASE_W-1:0] ctx_code, logic at_edge,
                                      logic off, logic [BASE_W-1:0] read_code);
    base_beat_t b;
    b.kind          = kind;
    b.on_neg_strand = neg;
    b.read_pos      = pos;
    b.ref_base      = ref_code;
    b.context_base  = ctx_code;
    b.at_chrom_edge = at_edge;
    b.off_chrom     = off;
    b.read_base     = read_code;
    return b;
  endfunction

  // mostly countable bases on a few hot bins, the rest is noise
  function automatic base_beat_t random_beat();
    base_beat_t b;
    b.kind          = ($urandom_range(99) < 20) ? KIND_READ : KIND_COUNT;
    b.on_neg_strand = 1'($urandom_range(1));
    b.read_pos      = ($urandom_range(1) != 0) ? POS_W'($urandom_range(7))
                                               : POS_W'($urandom());
    if ($urandom_range(3) != 0)
      b.ref_base = b.on_neg_strand ? BASE_G : BASE_C;
    else
      b.ref_base = BASE_W'($urandom());
    if ($urandom_range(2) == 0)
      b.context_base = b.on_neg_strand ? BASE_C : BASE_G;
    else
      b.context_base = BASE_W'($urandom());
    b.at_chrom_edge = ($urandom_range(4) == 0);
    b.off_chrom     = ($urandom_range(9) == 0);
    case ($urandom_range(9))
      0, 1, 2, 3: b.read_base = BASE_C;
      4, 5, 6, 7: b.read_base = BASE_T;
      default:    b.read_base = BASE_W'($urandom());
    endcase
    return b;
  endfunction

  // leaves s_tvalid high after the accepting edge so beats can run back to back
  task automatic send_beat(base_beat_t b);
    while (!calm && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(b[21:0]);
    s_tuser  <= b.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (b.kind == KIND_READ) reads_sent++;
    else counts_sent++;
  endtask

  // sender pauses until every owed report is in, then lets the pipe settle
  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tally.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of include_cpg with junk in the upper bits, then read back
  task automatic write_cpg(logic v);
    logic [31:0] word;
    word    = $urandom();
    word[0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_INCLUDE_CPG);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tally.cpg_on = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== v) begin
      $display("%0t: include_cpg read back expected %0d actual %0d", $time, v, prdata[0]);
      tally.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  initial begin
    tally = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_cpg(1'b0);

    // empty bins at both ends
    send_beat(beat(KIND_READ,  STRAND_FWD, 10'd0,    BASE_A, BASE_A, 0, 0, BASE_A));
    send_beat(beat(KIND_READ,  STRAND_REV, 10'd1023, BASE_A, BASE_A, 0, 0, BASE_A));
    // forward: unconverted, converted, n ignored, error codes
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_A, 0, 0, BASE_C));
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_T, 0, 0, BASE_T));
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_A, 0, 0, BASE_N));
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_A, 0, 0, BASE_A));
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_OTHER, 0, 0, BASE_SPARE_HI));
    // cpg skipped with counting off, but not across the chromosome edge
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_G, 0, 0, BASE_C));
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_C, BASE_G, 1, 0, BASE_C));
    // wrong reference for the strand
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0, BASE_G, BASE_A, 0, 0, BASE_C));
    // reverse strand, the same cases but for the ignored n
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_G, BASE_A, 0, 0, BASE_C));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_G, BASE_SPARE_LO, 0, 0, BASE_T));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_G, BASE_A, 0, 0, BASE_SPARE_LO));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_G, BASE_C, 0, 0, BASE_T));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_G, BASE_C, 1, 0, BASE_T));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_C, BASE_A, 0, 0, BASE_C));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_SPARE_HI, BASE_A, 0, 0, BASE_C));
    // past the chromosome end: overhang only, even for countable bases
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd0,    BASE_C, BASE_A, 0, 1, BASE_C));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd1023, BASE_G, BASE_A, 0, 1, BASE_T));
    send_beat(beat(KIND_READ,  STRAND_FWD, 10'd0,    BASE_A, BASE_A, 0, 0, BASE_A));
    send_beat(beat(KIND_READ,  STRAND_REV, 10'd1023, BASE_A, BASE_A, 0, 0, BASE_A));
    wait_for_reports();

    // cpg counting on
    write_cpg(1'b1);
    send_beat(beat(KIND_COUNT, STRAND_FWD, 10'd512, BASE_C, BASE_G, 0, 0, BASE_C));
    send_beat(beat(KIND_COUNT, STRAND_REV, 10'd512, BASE_G, BASE_C, 0, 0, BASE_OTHER));
    send_beat(beat(KIND_READ,  STRAND_FWD, 10'd512, BASE_A, BASE_A, 0, 0, BASE_A));
    send_beat(beat(KIND_READ,  STRAND_REV, 10'd0,   BASE_A, BASE_A, 0, 0, BASE_A));
    wait_for_reports();

    // random phases, alternating the register, one with a calm stretch
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_cpg(phase[0]);
      for (int n = 0; n < RANDOM_BEATS / NUM_PHASES; n++) begin
        calm = (phase == 2) && (n >= 80) && (n < 300);
        send_beat(random_beat());
      end
      calm = 1'b0;
      wait_for_reports();
    end

    $display("covered %0d count beats and %0d bin reads, %0d bin reports checked",
             counts_sent, reads_sent, tally.reports_seen);
    $display("include_cpg set %0d times over both values, with stalls and back-to-back beats",
             settings_used);
    if (tally.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bch_pkg.sv
rtl/bch_mem.sv
rtl/bch_rmw.sv
rtl/bisulfite_conversion_histogram_unit.sv
rtl/bch_checker.sv
test/bisulfite_conversion_histogram_unit_test.sv
